[design/lpip_pkg.sv]
`default_nettype none
package lpip_pkg;

	localparam int LEVEL_W           = 16;
	localparam int CHANNELS          = 5;
	localparam int ENTRY_W           = 9;
	localparam int CFG_W             = 10;
	localparam int PIU_RESET         = 300;
	localparam int DEF_TABLE_DEPTH   = 512;
	localparam int DEF_STEPS         = 36;
	localparam int KEYFRAME_W        = CHANNELS * LEVEL_W;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

	// Channel order inside a keyframe and a result
	localparam int CH_WHITE   = 0;
	localparam int CH_RED     = 1;
	localparam int CH_FAR_RED = 2;
	localparam int CH_PURPLE  = 3;
	localparam int CH_LIME    = 4;

	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef level_t [CHANNELS-1:0] keyframe_t;

	// Tick handed from the sequencer into the blend pipeline
	typedef struct packed {
		logic valid;
		logic manual;
	} tick_push_t;

	// Load enables for the lane stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage
`default_nettype wire

[design/lpip_if.sv]
`default_nettype none
interface lpip_item_if
	import lpip_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               kind;
	logic               manual_mode;
	logic [ENTRY_W-1:0] entry_index;
	logic [LEVEL_W-1:0] white_level;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] far_red_level;
	logic [LEVEL_W-1:0] purple_level;
	logic [LEVEL_W-1:0] lime_level;

	modport source (
		output valid, kind, manual_mode, entry_index,
		output white_level, red_level, far_red_level, purple_level, lime_level,
		input  ready
	);
	modport sink (
		input  valid, kind, manual_mode, entry_index,
		input  white_level, red_level, far_red_level, purple_level, lime_level,
		output ready
	);
endinterface

interface lpip_result_if
	import lpip_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] white_out;
	logic [LEVEL_W-1:0] red_out;
	logic [LEVEL_W-1:0] far_red_out;
	logic [LEVEL_W-1:0] purple_out;
	logic [LEVEL_W-1:0] lime_out;

	modport source (
		output valid, white_out, red_out, far_red_out, purple_out, lime_out,
		input  ready
	);
	modport sink (
		input  valid, white_out, red_out, far_red_out, purple_out, lime_out,
		output ready
	);
endinterface

interface lpip_cfg_if
	import lpip_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface
`default_nettype wire

[design/lpip_ram.sv]
`default_nettype none
module lpip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/lpip_ctrl.sv]
`default_nettype none
module lpip_ctrl
	import lpip_pkg::*;
#(
	parameter int TABLE_DEPTH       = DEF_TABLE_DEPTH,
	parameter int STEPS_PER_SEGMENT = DEF_STEPS,
	localparam int IDX_W            = $clog2(TABLE_DEPTH),
	localparam int STEP_W           = $clog2(STEPS_PER_SEGMENT + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               kind,
	input  wire logic               manual_mode,
	input  wire logic [ENTRY_W-1:0] entry_index,
	input  wire logic               cfg_we,
	input  wire logic [CFG_W-1:0]   cfg_data,
	output logic                    wr_en,
	output logic      [IDX_W-1:0]   wr_addr,
	output logic      [IDX_W-1:0]   rd_cur,
	output logic      [IDX_W-1:0]   rd_nxt,
	output logic      [STEP_W-1:0]  step,
	output tick_push_t              push
);

	localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W   = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;

	logic [CFG_W-1:0]  piu_q;
	logic [IDX_W-1:0]  pi_q;
	logic [STEP_W-1:0] step_q;

	logic [CNT_W-1:0]  piu_ext;
	logic [CNT_W-1:0]  n_active;
	logic [CNT_W-1:0]  cur_plus;
	logic [IDX_W-1:0]  cur;
	logic [IDX_W-1:0]  nxt;
	logic              tick_acc;
	logic              seg_end;

	always_comb begin
		piu_ext = CNT_W'(piu_q);
		priority if (piu_ext == '0) begin
			n_active = CNT_W'(1);
		end else if (piu_ext > CNT_W'(TABLE_DEPTH)) begin
			n_active = CNT_W'(TABLE_DEPTH);
		end else begin
			n_active = piu_ext;
		end

		cur      = (CNT_W'(pi_q) >= CNT_W'(TABLE_DEPTH)) ? '0 : pi_q;
		cur_plus = CNT_W'(cur) + CNT_W'(1);
		nxt      = (cur_plus >= n_active) ? '0 : cur_plus[IDX_W-1:0];
	end

	assign tick_acc = accept && (kind == KIND_TICK);
	assign seg_end  = (step_q == STEP_W'(STEPS_PER_SEGMENT));

	assign wr_en   = accept && (kind == KIND_WRITE)
		&& (CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH));
	assign wr_addr = IDX_W'(entry_index);
	assign rd_cur  = cur;
	assign rd_nxt  = nxt;
	assign step    = step_q;

	always_comb begin
		push.valid  = tick_acc;
		push.manual = manual_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q  <= CFG_W'(PIU_RESET);
			pi_q   <= '0;
			step_q <= '0;
		end else begin
			if (cfg_we) begin
				piu_q <= cfg_data;
			end
			if (tick_acc) begin
				priority if (manual_mode) begin
					pi_q   <= '0;
					step_q <= '0;
				end else if (seg_end) begin
					pi_q   <= nxt;
					step_q <= '0;
				end else begin
					pi_q   <= cur;
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(STEPS_PER_SEGMENT))
		else $error("step counter beyond segment length");

	a_manual_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && manual_mode) |=> (pi_q == '0 && step_q == '0))
		else $error("manual tick did not clear index and step");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && !manual_mode && !seg_end)
		|=> (step_q == STEP_W'($past(step_q) + STEP_W'(1)) && pi_q == $past(cur)))
		else $error("step did not advance within segment");

	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nxt == '0) || (CNT_W'(nxt) < n_active))
		else $error("next keyframe beyond points in use");

endmodule
`default_nettype wire

[design/lpip_lane.sv]
`default_nettype none
module lpip_lane
	import lpip_pkg::*;
#(
	parameter int STEPS_PER_SEGMENT = DEF_STEPS,
	localparam int STEP_W           = $clog2(STEPS_PER_SEGMENT + 1)
) (
	input  wire logic              clk,
	input  wire stage_en_t         en,
	input  wire logic [LEVEL_W-1:0] a,
	input  wire logic [LEVEL_W-1:0] b,
	input  wire logic [STEP_W-1:0] step,
	output logic      [LEVEL_W-1:0] level
);

	localparam int MAG_W   = LEVEL_W + STEP_W;
	localparam int DIVISOR = STEPS_PER_SEGMENT + 1;
	localparam int DIV_L   = $clog2(DIVISOR);
	localparam int SHIFT   = MAG_W + DIV_L;
	localparam int RECIP_W = MAG_W + 2;
	localparam int PROD_W  = MAG_W + RECIP_W;
	// ceil(2^SHIFT / DIVISOR): exact quotient for every MAG_W-bit dividend
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic [LEVEL_W-1:0] a_s2;
	logic               neg_s2;
	logic [MAG_W-1:0]   mag_s2;
	logic [LEVEL_W-1:0] a_s3;
	logic               neg_s3;
	logic [LEVEL_W-1:0] q_s3;

	logic               neg;
	logic [LEVEL_W-1:0] mag_diff;
	logic [PROD_W-1:0]  scaled;
	logic [LEVEL_W+1:0] sum;

	always_comb begin
		neg      = (b < a);
		mag_diff = neg ? (a - b) : (b - a);
		scaled   = PROD_W'(mag_s2) * PROD_W'(RECIP);
	end

	// Work on the magnitude; the sign is put back after the divide so the
	// quotient truncates toward zero
	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2   <= a;
			neg_s2 <= neg;
			mag_s2 <= MAG_W'(mag_diff) * MAG_W'(step);
		end
		if (en.s3) begin
			a_s3   <= a_s2;
			neg_s3 <= neg_s2;
			q_s3   <= LEVEL_W'(scaled >> SHIFT);
		end
	end

	always_comb begin
		sum = neg_s3 ? ({2'b00, a_s3} - {2'b00, q_s3}) : ({2'b00, a_s3} + {2'b00, q_s3});
		priority if (sum[LEVEL_W+1]) begin
			level = '0;
		end else if (sum[LEVEL_W]) begin
			level = LEVEL_MAX;
		end else begin
			level = sum[LEVEL_W-1:0];
		end
	end

endmodule
`default_nettype wire

[design/lpip_blend_pipe.sv]
`default_nettype none
module lpip_blend_pipe
	import lpip_pkg::*;
#(
	parameter int STEPS_PER_SEGMENT = DEF_STEPS,
	localparam int STEP_W           = $clog2(STEPS_PER_SEGMENT + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tick_push_t        push,
	input  wire logic [STEP_W-1:0] step_in,
	input  wire keyframe_t         kf_cur,
	input  wire keyframe_t         kf_nxt,
	output logic                   load_s1,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output keyframe_t              out_level
);

	logic              v_s1, v_s2, v_s3;
	logic              m_s1, m_s2, m_s3;
	logic [STEP_W-1:0] step_s1;
	logic              out_valid_q;
	keyframe_t         out_level_q;

	logic              en_o;
	stage_en_t         en;
	keyframe_t         lane_level;
	keyframe_t         manual_level;

	// A stage loads when it is empty or the stage after it loads too
	always_comb begin
		en_o    = !out_valid_q || out_ready;
		en.s3   = !v_s3 || en_o;
		en.s2   = !v_s2 || en.s3;
		load_s1 = !v_s1 || en.s2;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		lpip_lane #(
			.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.a    (kf_cur[c]),
			.b    (kf_nxt[c]),
			.step (step_s1),
			.level(lane_level[c])
		);
	end

	always_comb begin
		manual_level           = '0;
		manual_level[CH_WHITE] = LEVEL_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= push.valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			m_s1    <= push.manual;
			step_s1 <= step_in;
		end
		if (en.s2) begin
			m_s2 <= m_s1;
		end
		if (en.s3) begin
			m_s3 <= m_s2;
		end
		if (en_o) begin
			out_level_q <= m_s3 ? manual_level : lane_level;
		end
	end

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;

endmodule
`default_nettype wire

[design/lighting_profile_interpolating_player_core.sv]
`default_nettype none
// Keyframe LED player: write beats load one five-channel keyframe into the
// table and give no result; every tick beat gives one result, either the
// linear blend of the current and next keyframe at the current step or, in
// manual mode, full white. The block takes one beat per clock cycle while
// results are taken, writes and ticks mixed freely. The table is read at
// the edge that takes a tick; then come the step product, the reciprocal
// divide and the output register. The table is held in two RAM copies
// written together, so the current and next keyframes come out of their
// own read ports in the same cycle. The four stages drain independently,
// so beats are still taken while a result waits, until every stage holds
// a tick. The configuration port is always ready. The table is not
// cleared after reset: load every keyframe in use before the first tick.
module lighting_profile_interpolating_player_core
	import lpip_pkg::*;
#(
	parameter int TABLE_DEPTH       = DEF_TABLE_DEPTH,
	parameter int STEPS_PER_SEGMENT = DEF_STEPS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lpip_item_if.sink     items,
	lpip_result_if.source results,
	lpip_cfg_if.sink      cfg
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int STEP_W = $clog2(STEPS_PER_SEGMENT + 1);

	logic              accept;
	logic              load_s1;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_cur;
	logic [IDX_W-1:0]  rd_nxt;
	logic [STEP_W-1:0] step;
	tick_push_t        push;
	keyframe_t         wr_kf;
	keyframe_t         kf_cur;
	keyframe_t         kf_nxt;
	keyframe_t         out_level;

	assign items.ready = load_s1;
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	always_comb begin
		wr_kf[CH_WHITE]   = items.white_level;
		wr_kf[CH_RED]     = items.red_level;
		wr_kf[CH_FAR_RED] = items.far_red_level;
		wr_kf[CH_PURPLE]  = items.purple_level;
		wr_kf[CH_LIME]    = items.lime_level;
	end

	lpip_ctrl #(
		.TABLE_DEPTH      (TABLE_DEPTH),
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (items.kind),
		.manual_mode(items.manual_mode),
		.entry_index(items.entry_index),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_data   (cfg.data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_cur     (rd_cur),
		.rd_nxt     (rd_nxt),
		.step       (step),
		.push       (push)
	);

	lpip_ram #(
		.WIDTH(KEYFRAME_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram_cur (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_kf),
		.re   (load_s1),
		.raddr(rd_cur),
		.rdata(kf_cur)
	);

	lpip_ram #(
		.WIDTH(KEYFRAME_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram_nxt (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_kf),
		.re   (load_s1),
		.raddr(rd_nxt),
		.rdata(kf_nxt)
	);

	lpip_blend_pipe #(
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.step_in  (step),
		.kf_cur   (kf_cur),
		.kf_nxt   (kf_nxt),
		.load_s1  (load_s1),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.out_level(out_level)
	);

	assign results.white_out   = out_level[CH_WHITE];
	assign results.red_out     = out_level[CH_RED];
	assign results.far_red_out = out_level[CH_FAR_RED];
	assign results.purple_out  = out_level[CH_PURPLE];
	assign results.lime_out    = out_level[CH_LIME];

endmodule
`default_nettype wire
